### rtl/core/srbtb_pkg.sv
// shared types and constants of the branch target predictor
// no dependencies
package srbtb_pkg;

	localparam int OUT_BITS   = 48;
	localparam int CFG_IDX_W  = 8;
	localparam int SIZE_W     = 4;
	localparam int RRPV_W     = 2;
	localparam int HIST_W     = 64;

	localparam logic [RRPV_W-1:0] RRPV_NEAR    = 2'd0;
	localparam logic [RRPV_W-1:0] RRPV_LONG    = 2'd2;
	localparam logic [RRPV_W-1:0] RRPV_DISTANT = 2'd3;
	localparam logic [SIZE_W-1:0] SIZE_RESET   = 4'd4;
	localparam int               SIZE_LIMIT   = 10;

	typedef enum logic [1:0] {
		OP_PREDICT  = 2'd0,
		OP_UPDATE   = 2'd1,
		OP_PREFETCH = 2'd2,
		OP_NONE     = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		K_JUMP     = 3'd0,
		K_INDIRECT = 3'd1,
		K_COND     = 3'd2,
		K_CALL     = 3'd3,
		K_ICALL    = 3'd4,
		K_RETURN   = 3'd5,
		K_OTHER    = 3'd6,
		K_SPARE    = 3'd7
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SECOND_TOUCH  = 8'd0,
		CFG_TAKEN_REFRESH = 8'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

endpackage

### rtl/core/srrip_btb_with_ras_and_indirect_core.sv
// branch target predictor top level: btb with srrip, indirect table, return stack
// depends on srbtb_pkg and srbtb_ram
//
// Branches are handled one at a time: the accept cycle issues the reads of the
// btb set row, the indirect table and the call-size table, and the next cycle
// computes the result, writes the modified entries back and loads the output
// register. That cycle waits while the previous result has not been taken, and
// a new branch is taken while a result waits. After reset a clearing pass over
// max(SETS, INDIRECT_DEPTH, CALL_TRACKERS) addresses (4096 by default) initializes
// the memories; no branch is taken during it, configuration writes are. Table
// depths are expected to be powers of two.
module srrip_btb_with_ras_and_indirect_core #(
	parameter int SETS           = 2048,
	parameter int WAYS           = 4,
	parameter int INDIRECT_DEPTH = 4096,
	parameter int RAS_DEPTH      = 32,
	parameter int CALL_TRACKERS  = 1024,
	parameter int ADDR_BITS      = 48
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        opcode,
	input  logic [ADDR_BITS-1:0]              branch_addr,
	input  logic [2:0]                        kind,
	input  logic [ADDR_BITS-1:0]              resolved_target,
	input  logic                              was_taken,
	input  logic                              friendly_hint,
	input  logic                              skip_allocate,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [srbtb_pkg::OUT_BITS-1:0]    predicted_target,
	output logic                              always_taken_bit,
	output logic                              btb_hit,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [srbtb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic                              cfg_data
);
	import srbtb_pkg::*;

	localparam int SIW  = $clog2(SETS);
	localparam int IIW  = $clog2(INDIRECT_DEPTH);
	localparam int CIW  = $clog2(CALL_TRACKERS);
	localparam int RW   = $clog2(RAS_DEPTH);
	localparam int WW   = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int MAXD = (SETS > INDIRECT_DEPTH) ?
		((SETS > CALL_TRACKERS) ? SETS : CALL_TRACKERS) :
		((INDIRECT_DEPTH > CALL_TRACKERS) ? INDIRECT_DEPTH : CALL_TRACKERS);
	localparam int CLRW = $clog2(MAXD) + 1;

	typedef struct packed {
		logic [ADDR_BITS-1:0] tag;
		logic [ADDR_BITS-1:0] target;
		logic                 sticky_taken;
		logic [RRPV_W-1:0]    rrpv;
		logic                 touched;
	} way_t;

	typedef way_t [WAYS-1:0] row_t;

	state_t state_q, state_d;
	logic [CLRW-1:0] clr_q;

	logic second_touch_q, refresh_taken_q;
	logic [HIST_W-1:0] hist_q;
	logic [ADDR_BITS-1:0] ras_q [RAS_DEPTH];
	logic [RW-1:0] top_q;

	logic [1:0]           op_q;
	logic [ADDR_BITS-1:0] addr_q, tgt_q;
	logic [2:0]           kind_q;
	logic                 taken_q, hint_q, skip_q;

	logic                 out_valid_q;
	logic [OUT_BITS-1:0]  out_tgt_q;
	logic                 out_at_q, out_hit_q;

	// memory ports
	logic            btb_we, btb_re, ind_we, ind_re, cs_we, cs_re;
	logic [SIW-1:0]  btb_waddr, btb_raddr;
	logic [IIW-1:0]  ind_waddr, ind_raddr;
	logic [CIW-1:0]  cs_waddr, cs_raddr;
	row_t            btb_wdata, btb_rdata;
	logic [ADDR_BITS-1:0] ind_wdata, ind_rdata;
	logic [SIZE_W-1:0]    cs_wdata, cs_rdata;

	srbtb_ram #(.WIDTH($bits(row_t)), .DEPTH(SETS)) u_btb (
		.clk(clk), .we(btb_we), .waddr(btb_waddr), .wdata(btb_wdata),
		.re(btb_re), .raddr(btb_raddr), .rdata(btb_rdata));
	srbtb_ram #(.WIDTH(ADDR_BITS), .DEPTH(INDIRECT_DEPTH)) u_ind (
		.clk(clk), .we(ind_we), .waddr(ind_waddr), .wdata(ind_wdata),
		.re(ind_re), .raddr(ind_raddr), .rdata(ind_rdata));
	srbtb_ram #(.WIDTH(SIZE_W), .DEPTH(CALL_TRACKERS)) u_cs (
		.clk(clk), .we(cs_we), .waddr(cs_waddr), .wdata(cs_wdata),
		.re(cs_re), .raddr(cs_raddr), .rdata(cs_rdata));

	logic in_xfer, done;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign done      = (state_q == ST_EXEC) && (!out_valid_q || out_ready);
	assign cfg_ready = 1'b1;

	// read side, issued in the accept cycle
	logic [ADDR_BITS-1:0] ras_top_val;
	assign ras_top_val = ras_q[top_q];
	assign btb_re    = in_xfer;
	assign btb_raddr = branch_addr[2 +: SIW];
	assign ind_re    = in_xfer;
	assign ind_raddr = branch_addr[2 +: IIW] ^ hist_q[IIW-1:0];
	assign cs_re     = in_xfer;
	assign cs_raddr  = ras_top_val[CIW-1:0];

	// execute stage
	row_t row, aged;
	logic found;
	logic [WW-1:0] hw, vw;
	logic vfound;
	logic [RRPV_W-1:0] mx, add;
	logic do_train, alloc, is_ind;
	row_t row_new;
	logic row_we;
	logic [ADDR_BITS-1:0] c_val, diff, ptarget;
	logic at, hitbit;
	logic [RW-1:0] top_push, top_pop;

	always_comb begin
		row    = btb_rdata;
		found  = 1'b0;
		hw     = '0;
		mx     = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (!found && row[w].tag == addr_q) begin
				found = 1'b1;
				hw    = WW'(w);
			end
			if (row[w].rrpv > mx) mx = row[w].rrpv;
		end
		add    = RRPV_DISTANT - mx;
		aged   = row;
		vfound = 1'b0;
		vw     = '0;
		for (int w = 0; w < WAYS; w++) begin
			aged[w].rrpv = row[w].rrpv + add;
			if (!vfound && aged[w].rrpv == RRPV_DISTANT) begin
				vfound = 1'b1;
				vw     = WW'(w);
			end
		end

		is_ind   = (kind_q inside {K_INDIRECT, K_ICALL});
		do_train = ((op_q == OP_UPDATE) || (op_q == OP_PREFETCH)) &&
			!is_ind && (kind_q != K_RETURN);
		alloc    = (op_q == OP_UPDATE) || !skip_q;

		row_new = row;
		row_we  = 1'b0;
		if (do_train) begin
			if (!found) begin
				if (tgt_q != '0 && taken_q && alloc) begin
					row_new                  = aged;
					row_new[vw].tag          = addr_q;
					row_new[vw].target       = tgt_q;
					row_new[vw].sticky_taken = 1'b1;
					row_new[vw].rrpv         = hint_q ? RRPV_NEAR : RRPV_LONG;
					row_new[vw].touched      = !hint_q;
					row_we                   = 1'b1;
				end
			end else begin
				row_we = 1'b1;
				if (!refresh_taken_q || taken_q) begin
					if (!second_touch_q || row[hw].touched) begin
						row_new[hw].rrpv = RRPV_NEAR;
					end else begin
						row_new[hw].rrpv    = RRPV_DISTANT;
						row_new[hw].touched = 1'b1;
					end
				end
				if (!taken_q) row_new[hw].sticky_taken = 1'b0;
				else row_new[hw].target = tgt_q;
			end
		end

		c_val   = ras_top_val;
		diff    = (c_val > tgt_q) ? (c_val - tgt_q) : (tgt_q - c_val);
		top_push = (top_q == RW'(RAS_DEPTH - 1)) ? '0 : top_q + 1'b1;
		top_pop  = (top_q == '0) ? RW'(RAS_DEPTH - 1) : top_q - 1'b1;

		ptarget = '0;
		at      = 1'b0;
		hitbit  = 1'b0;
		if (op_q == OP_PREDICT) begin
			at = (kind_q != K_COND);
			if (kind_q == K_RETURN) begin
				ptarget = c_val + ADDR_BITS'(cs_rdata);
			end else if (is_ind) begin
				ptarget = ind_rdata;
			end else if (!found) begin
				at = 1'b1;
			end else begin
				ptarget = row[hw].target;
				at      = row[hw].sticky_taken;
				hitbit  = 1'b1;
			end
		end
	end

	// write side: clearing pass or execute write-back
	always_comb begin
		btb_we    = 1'b0;
		btb_waddr = btb_raddr;
		for (int w = 0; w < WAYS; w++) begin
			btb_wdata[w]      = '0;
			btb_wdata[w].rrpv = RRPV_DISTANT;
		end
		ind_we    = 1'b0;
		ind_waddr = clr_q[IIW-1:0];
		ind_wdata = '0;
		cs_we     = 1'b0;
		cs_waddr  = clr_q[CIW-1:0];
		cs_wdata  = SIZE_RESET;
		if (state_q == ST_CLEAR) begin
			btb_waddr = clr_q[SIW-1:0];
			btb_we    = (clr_q < CLRW'(SETS));
			ind_we    = (clr_q < CLRW'(INDIRECT_DEPTH));
			cs_we     = (clr_q < CLRW'(CALL_TRACKERS));
		end else if (done) begin
			btb_waddr = addr_q[2 +: SIW];
			btb_wdata = row_new;
			btb_we    = row_we;
			ind_waddr = addr_q[2 +: IIW] ^ hist_q[IIW-1:0];
			ind_wdata = tgt_q;
			ind_we    = (op_q == OP_UPDATE) && is_ind;
			cs_waddr  = c_val[CIW-1:0];
			cs_wdata  = diff[SIZE_W-1:0];
			cs_we     = (op_q == OP_UPDATE) && (kind_q == K_RETURN) &&
				(diff <= ADDR_BITS'(SIZE_LIMIT));
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == CLRW'(MAXD - 1)) state_d = ST_IDLE;
			ST_IDLE:  if (in_xfer) state_d = ST_EXEC;
			ST_EXEC:  if (done) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_CLEAR;
			clr_q           <= '0;
			second_touch_q  <= 1'b0;
			refresh_taken_q <= 1'b0;
			hist_q          <= '0;
			top_q           <= '0;
			out_valid_q     <= 1'b0;
			for (int i = 0; i < RAS_DEPTH; i++) ras_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_SECOND_TOUCH)  second_touch_q  <= cfg_data;
				if (cfg_index == CFG_TAKEN_REFRESH) refresh_taken_q <= cfg_data;
			end
			if (done) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (done) begin
				if (op_q == OP_PREDICT && (kind_q == K_CALL || kind_q == K_ICALL)) begin
					top_q         <= top_push;
					ras_q[top_push] <= addr_q;
				end
				if (op_q == OP_UPDATE && kind_q == K_COND)
					hist_q <= {hist_q[HIST_W-2:0], taken_q};
				if (op_q == OP_UPDATE && kind_q == K_RETURN) begin
					ras_q[top_q] <= '0;
					top_q        <= top_pop;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q    <= opcode;
			addr_q  <= branch_addr;
			kind_q  <= kind;
			tgt_q   <= resolved_target;
			taken_q <= was_taken;
			hint_q  <= friendly_hint;
			skip_q  <= skip_allocate;
		end
		if (done) begin
			out_tgt_q <= OUT_BITS'(ptarget);
			out_at_q  <= at;
			out_hit_q <= hitbit;
		end
	end

	assign out_valid        = out_valid_q;
	assign predicted_target = out_tgt_q;
	assign always_taken_bit = out_at_q;
	assign btb_hit          = out_hit_q;
endmodule

### rtl/core/srbtb_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module srbtb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end
endmodule

### rtl/core/srbtb_chk.sv
// port-level checks of the branch target predictor, bound to the top level
// depends on srbtb_pkg
module srbtb_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [srbtb_pkg::OUT_BITS-1:0]  predicted_target
);
	import srbtb_pkg::*;

	// one branch in flight: no new transfer right after one
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken twice in a row");

	// a result needs the execute cycle after the accept
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("result shown in the cycle after accept");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(predicted_target))
		else $error("stalled result changed");
endmodule

bind srrip_btb_with_ras_and_indirect_core srbtb_chk u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready),
	.predicted_target(predicted_target));
